[hdl/spd_pkg.sv]
// Shared types, constants and tables for the scope peak decimator.
package spd_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_COLUMNS  = 1024;
   localparam int SAMPLE_BITS  = 16;

   localparam int GAIN_FRAC_BITS = 8;
   localparam int SCALE_SHIFT    = (SAMPLE_BITS - 1) + GAIN_FRAC_BITS + 1;
   localparam int HEIGHT_LIMIT   = 10240;

   localparam int RECIP_SHIFT = 22;
   localparam int MUL_A_BITS  = 32;
   localparam int MUL_B_BITS  = 23;
   localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;

   localparam logic [3:0]  RESET_CHANNEL_SELECT = 4'd0;
   localparam logic [3:0]  RESET_CHANNEL_COUNT  = 4'd2;
   localparam logic [4:0]  RESET_DECIMATION     = 5'd1;
   localparam logic [12:0] RESET_Y_GAIN         = 13'd256;
   localparam logic [10:0] RESET_DISPLAY_HEIGHT = 11'd256;
   localparam logic [10:0] RESET_COLUMN_COUNT   = 11'd512;

   typedef enum logic [2:0] {
      CSR_CHANNEL_SELECT  = 3'd0,
      CSR_CHANNEL_COUNT   = 3'd1,
      CSR_DECIMATION      = 3'd2,
      CSR_Y_GAIN          = 3'd3,
      CSR_DISPLAY_HEIGHT  = 3'd4,
      CSR_COLUMN_COUNT    = 3'd5,
      CSR_FREEZE          = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_COMPARE,
      ST_SCALE_GAIN,
      ST_SCALE_HEIGHT,
      ST_EMIT
   } spd_state_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_DIV,
      MUL_GAIN,
      MUL_HEIGHT
   } mul_op_type;

   // ceil(2^22 / c): exact quotient for dividends below 2^19
   function automatic logic [MUL_B_BITS-1:0] recip(input logic [3:0] c);
      logic [MUL_B_BITS-1:0] r;
      case (c)
         4'd2:    r = 23'd2097152;
         4'd3:    r = 23'd1398102;
         4'd4:    r = 23'd1048576;
         4'd5:    r = 23'd838861;
         4'd6:    r = 23'd699051;
         4'd7:    r = 23'd599187;
         4'd8:    r = 23'd524288;
         default: r = 23'd4194304;
      endcase
      return r;
   endfunction

endpackage

[hdl/spd_mul_unit.sv]
// Shared multiplier: frame-average reciprocal divide and two-step height scaling.
module spd_mul_unit
   import spd_pkg::*;
(
   input  logic                   clock,
   input  mul_op_type             op,
   input  logic [18:0]            sum_mag,
   input  logic [3:0]             count,
   input  logic [18:0]            peak_mag,
   input  logic [12:0]            y_gain,
   input  logic [10:0]            display_height,
   output logic [MUL_P_BITS-1:0]  product
);

   logic [MUL_A_BITS-1:0] mul_a;
   logic [MUL_B_BITS-1:0] mul_b;
   logic [MUL_P_BITS-1:0] product_ff;
   logic [MUL_P_BITS-1:0] product_in;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         MUL_DIV: begin
            mul_a = MUL_A_BITS'(sum_mag);
            mul_b = recip(count);
         end
         MUL_GAIN: begin
            mul_a = MUL_A_BITS'(peak_mag);
            mul_b = MUL_B_BITS'(y_gain);
         end
         MUL_HEIGHT: begin
            mul_a = product_ff[MUL_A_BITS-1:0];
            mul_b = MUL_B_BITS'(display_height);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product_in = (op == MUL_HOLD) ? product_ff
                                    : MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[hdl/scope_peak_decimator_core.sv]
// Scope peak decimator top level: sequencer, trace state, CSRs and result register.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  req      | in        | req_tvalid/req_tready | tdata: sample[15:0]; tuser: start_of_pass
//  rsp      | out       | rsp_tvalid/rsp_tready | tdata: column, height_px; tlast: last col
//  csr      | in        | csr_valid/csr_ready   | csr_index[2:0], csr_data[12:0]
//
// An item mid-frame passes through accept, accumulate and compare; averaging the frame
// adds the reciprocal multiply; ending a column adds two passes through the shared
// multiplier, then saturate and load, held while the result register is full. Ignored
// items (frozen, or no pass active) are dropped in idle. Synchronous active-high reset
// restores register defaults and waits for a start flag. csr is always ready.
module scope_peak_decimator_core
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] start_of_pass
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [9:0] column, [24:10] height_px, [31:25] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);

   spd_state_type state_ff, state_in;

   logic [3:0]  chan_sel_ff, chan_sel_in;
   logic [3:0]  chan_cnt_ff, chan_cnt_in;
   logic [4:0]  decim_ff, decim_in;
   logic [12:0] y_gain_ff, y_gain_in;
   logic [10:0] disp_h_ff, disp_h_in;
   logic [10:0] col_cnt_ff, col_cnt_in;
   logic        freeze_ff, freeze_in;

   logic [2:0]         pos_ff, pos_in;
   logic [4:0]         frame_ff, frame_in;
   logic [9:0]         col_ff, col_in;
   logic signed [18:0] sum_ff, sum_in;
   logic signed [19:0] peak_ff, peak_in;
   logic               pass_ff, pass_in;

   logic signed [15:0] sample_ff, sample_in;
   logic signed [19:0] cand_ff, cand_in;
   logic               have_ff, have_in;
   logic               sum_neg_ff, sum_neg_in;
   logic               scale_neg_ff, scale_neg_in;
   logic [9:0]         out_col_ff, out_col_in;
   logic               out_last_ff, out_last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_col_ff, rsp_col_in;
   logic signed [14:0] rsp_height_ff, rsp_height_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [3:0]          cnt_eff;
   logic [4:0]          dec_eff;
   logic [10:0]         cols_eff;
   logic                last_chan;
   logic                req_accept;
   logic                out_load;
   logic signed [18:0]  sum_total;
   logic [18:0]         sum_mag;
   logic [18:0]         peak_mag;
   logic signed [19:0]  peak_new;
   logic [19:0]         quot;
   logic [30:0]         scaled;
   logic [14:0]         sat_mag;
   mul_op_type          mul_op;
   logic [MUL_P_BITS-1:0] product;

   function automatic logic [19:0] mag20(input logic signed [19:0] x);
      return x[19] ? 20'(-x) : 20'(x);
   endfunction

   spd_mul_unit u_mul (
      .clock          (clock),
      .op             (mul_op),
      .sum_mag        (sum_mag),
      .count          (cnt_eff),
      .peak_mag       (peak_mag),
      .y_gain         (y_gain_ff),
      .display_height (disp_h_ff),
      .product        (product)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign cnt_eff  = (chan_cnt_ff == 4'd0) ? 4'd1
                   : (chan_cnt_ff > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chan_cnt_ff;
   assign dec_eff  = (decim_ff == 5'd0) ? 5'd1 : decim_ff;
   assign cols_eff = (col_cnt_ff == 11'd0) ? 11'd1
                   : (col_cnt_ff > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS) : col_cnt_ff;
   assign last_chan = ({1'b0, pos_ff} + 4'd1) >= cnt_eff;

   assign sum_total = sum_ff + 19'(sample_ff);
   assign sum_mag   = sum_total[18] ? 19'(-sum_total) : 19'(sum_total);
   assign peak_mag  = 19'(mag20(peak_ff));
   assign peak_new  = (have_ff && (mag20(cand_ff) > mag20(peak_ff))) ? 20'(-cand_ff) : peak_ff;
   assign quot      = product[RECIP_SHIFT+19:RECIP_SHIFT];
   assign scaled    = product[MUL_P_BITS-1:SCALE_SHIFT];
   assign sat_mag   = (scaled > 31'(HEIGHT_LIMIT)) ? 15'(HEIGHT_LIMIT) : scaled[14:0];

   always_comb begin
      chan_sel_in = chan_sel_ff;
      chan_cnt_in = chan_cnt_ff;
      decim_in    = decim_ff;
      y_gain_in   = y_gain_ff;
      disp_h_in   = disp_h_ff;
      col_cnt_in  = col_cnt_ff;
      freeze_in   = freeze_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHANNEL_SELECT: chan_sel_in = csr_data[3:0];
            CSR_CHANNEL_COUNT:  chan_cnt_in = csr_data[3:0];
            CSR_DECIMATION:     decim_in    = csr_data[4:0];
            CSR_Y_GAIN:         y_gain_in   = csr_data;
            CSR_DISPLAY_HEIGHT: disp_h_in   = csr_data[10:0];
            CSR_COLUMN_COUNT:   col_cnt_in  = csr_data[10:0];
            CSR_FREEZE:         freeze_in   = csr_data[0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      col_in       = col_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      pass_in      = pass_ff;
      sample_in    = sample_ff;
      cand_in      = cand_ff;
      have_in      = have_ff;
      sum_neg_in   = sum_neg_ff;
      scale_neg_in = scale_neg_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      mul_op       = MUL_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !freeze_ff) begin
               sample_in = req_tdata;
               if (req_tuser) begin
                  pos_in   = '0;
                  frame_in = '0;
                  col_in   = '0;
                  sum_in   = '0;
                  peak_in  = '0;
                  pass_in  = 1'b1;
                  state_in = ST_ACCUM;
               end else if (pass_ff) begin
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            have_in = 1'b0;
            cand_in = 20'(sample_ff);
            state_in = ST_COMPARE;
            if (chan_sel_ff == 4'd0) begin
               if (last_chan) begin
                  sum_in     = '0;
                  sum_neg_in = sum_total[18];
                  mul_op     = MUL_DIV;
                  state_in   = ST_DIVIDE;
               end else begin
                  sum_in = sum_total;
               end
            end else if (({1'b0, pos_ff} + 4'd1) == chan_sel_ff) begin
               have_in = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cand_in  = sum_neg_ff ? 20'(-quot) : quot;
            have_in  = 1'b1;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            peak_in  = peak_new;
            state_in = ST_IDLE;
            if (!last_chan) begin
               pos_in = pos_ff + 3'd1;
            end else begin
               pos_in = '0;
               if ((6'(frame_ff) + 6'd1) < 6'(dec_eff)) begin
                  frame_in = frame_ff + 5'd1;
               end else begin
                  frame_in    = '0;
                  out_col_in  = col_ff;
                  out_last_in = (11'(col_ff) + 11'd1) >= cols_eff;
                  if ((11'(col_ff) + 11'd1) >= cols_eff) begin
                     pass_in = 1'b0;
                     col_in  = '0;
                  end else begin
                     col_in = col_ff + 10'd1;
                  end
                  if (chan_sel_ff <= cnt_eff) begin
                     state_in = ST_SCALE_GAIN;
                  end else begin
                     peak_in = '0;
                  end
               end
            end
         end
         ST_SCALE_GAIN: begin
            mul_op       = MUL_GAIN;
            scale_neg_in = peak_ff[19];
            peak_in      = '0;
            state_in     = ST_SCALE_HEIGHT;
         end
         ST_SCALE_HEIGHT: begin
            mul_op   = MUL_HEIGHT;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_col_in    = out_col_ff;
         rsp_height_in = scale_neg_ff ? 15'(-sat_mag) : sat_mag;
         rsp_last_in   = out_last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_sel_ff  <= RESET_CHANNEL_SELECT;
         chan_cnt_ff  <= RESET_CHANNEL_COUNT;
         decim_ff     <= RESET_DECIMATION;
         y_gain_ff    <= RESET_Y_GAIN;
         disp_h_ff    <= RESET_DISPLAY_HEIGHT;
         col_cnt_ff   <= RESET_COLUMN_COUNT;
         freeze_ff    <= 1'b0;
         pos_ff       <= '0;
         frame_ff     <= '0;
         col_ff       <= '0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_sel_ff  <= chan_sel_in;
         chan_cnt_ff  <= chan_cnt_in;
         decim_ff     <= decim_in;
         y_gain_ff    <= y_gain_in;
         disp_h_ff    <= disp_h_in;
         col_cnt_ff   <= col_cnt_in;
         freeze_ff    <= freeze_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         col_ff       <= col_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      cand_ff       <= cand_in;
      have_ff       <= have_in;
      sum_neg_ff    <= sum_neg_in;
      scale_neg_ff  <= scale_neg_in;
      out_col_ff    <= out_col_in;
      out_last_ff   <= out_last_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_height_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_height_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_height_ff <= 15'sd10240) && (rsp_height_ff >= -15'sd10240))
      else $error("height_px outside saturation range");

   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ($past(state_ff) == ST_SCALE_HEIGHT)
                                || ($past(state_ff) == ST_EMIT))
      else $error("result emitted without scaling");

   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last_ff) |=> !pass_ff)
      else $error("pass still active after last column");

endmodule
